// ===== sv/mse_pkg.sv =====
// Shared types for the merge sort engine.
package mse_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_LOAD    = 5'b00001,
        S_PRIME_A = 5'b00010,
        S_PRIME_B = 5'b00100,
        S_MERGE   = 5'b01000,
        S_EMIT    = 5'b10000
    } t_state;

    // Width of the value fields on the ports.
    localparam int PORT_WIDTH = 32;

endpackage

// ===== sv/mse_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/merge_sort_engine_top.sv =====
// Merge sort engine: collects a set of signed values, sorts them bottom-up, streams them out.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_in_sample_value, i_in_final_item
//  out     | source    | o_out_valid / i_out_stall | o_out_sorted_value, o_out_end_of_run,
//          |           |                           | o_out_dropped_items
//
//  Loading: one transfer per cycle, values go straight into the work RAM.
//  Sorting: each pass primes each pair of runs (one or two heads fetched through the
//    single read port) and then merges it; ceil(log2 n) passes.
//  Emitting: the RAM read is registered, and only one read is in flight ahead of the
//    output register; a new read is not issued while one is pending.
//  Reset (i_rst_n low, synchronous) clears the control state only; RAM contents are never
//    read before they are written, so no clearing pass is needed.
//  o_in_stall is high from the final transfer of a set until the last read of the
//    emission is issued; i_out_stall just holds the output register and pauses emission.
module merge_sort_engine_top import mse_pkg::*; #(
    parameter int MAX_ITEMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [PORT_WIDTH-1:0] i_in_sample_value,
    input  logic                         i_in_final_item,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [PORT_WIDTH-1:0] o_out_sorted_value,
    output logic                         o_out_end_of_run,
    output logic                         o_out_dropped_items
);

    localparam int AW = $clog2(MAX_ITEMS);      // RAM address bits
    localparam int CW = $clog2(MAX_ITEMS + 1);  // counts and indexes, can hold MAX_ITEMS
    localparam int WW = CW + 1;                 // run width, can hold twice a run below n
    localparam int SW = CW + 2;                 // sums of an index and a doubled run width

    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;    // values stored in the current set
    logic [CW-1:0] r_lo, n_lo;          // start of the current pair of runs
    logic [CW-1:0] r_mid, n_mid;        // start of the right run
    logic [CW-1:0] r_hi, n_hi;          // end of the right run
    logic [CW-1:0] r_i, n_i;            // left run cursor
    logic [CW-1:0] r_j, n_j;            // right run cursor
    logic [CW-1:0] r_k, n_k;            // write cursor (merge) / read cursor (emit)
    logic [WW-1:0] r_width, n_width;    // current run width

    logic r_src, n_src;                 // 0: RAM A is the source of the pass, 1: RAM B
    logic r_ovf, n_ovf;                 // a transfer of this set was dropped
    logic r_set_drop, n_set_drop;       // drop flag frozen for the set being emitted
    logic r_fresh_a, n_fresh_a;         // read data this cycle is the new left head
    logic r_fresh_b, n_fresh_b;         // read data this cycle is the new right head
    logic r_rd_pending, n_rd_pending;   // emission read returns this cycle
    logic r_rd_last, n_rd_last;         // ... and it is the last value of the set
    logic r_out_valid, n_out_valid;

    // payload registers, no reset
    logic signed [DATA_WIDTH-1:0] r_head_a, r_head_b;
    logic signed [PORT_WIDTH-1:0] r_out_value;
    logic                         r_out_end, r_out_drop;

    // ------------------------------------------------------------------
    // RAMs: ping-pong between passes instead of copying back
    // ------------------------------------------------------------------
    logic                  we_a, we_b;
    logic [AW-1:0]         waddr, raddr;
    logic [DATA_WIDTH-1:0] wr_data, rdata_a, rdata_b;

    mse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ITEMS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wr_data),
        .i_raddr (raddr),
        .o_rdata (rdata_a)
    );

    mse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ITEMS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wr_data),
        .i_raddr (raddr),
        .o_rdata (rdata_b)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic signed [DATA_WIDTH-1:0] in_value, rdata, head_a, head_b;
    logic                         in_accept, out_take;
    logic                         stored, i_done, j_done, take_a;
    logic [CW-1:0]                count_after, i_nxt, j_nxt, k_nxt, mid_c, hi_c;
    logic [SW-1:0]                mid_sum, hi_sum, cnt_ext;
    logic [WW-1:0]                width2;

    // sign-extend or truncate the port value to the held width
    assign in_value = DATA_WIDTH'(i_in_sample_value);

    assign in_accept = i_in_valid && (r_state == S_LOAD);
    assign out_take  = r_out_valid && !i_out_stall;

    assign rdata  = r_src ? $signed(rdata_b) : $signed(rdata_a);
    // a head refetched last cycle comes straight from the read port
    assign head_a = r_fresh_a ? rdata : r_head_a;
    assign head_b = r_fresh_b ? rdata : r_head_b;

    assign i_done = (r_i >= r_mid);
    assign j_done = (r_j >= r_hi);
    // equal values: right run goes first
    assign take_a = !i_done && (j_done || (head_a < head_b));

    assign stored      = (r_count != MAX_C);
    assign count_after = stored ? r_count + ONE_C : r_count;
    assign i_nxt       = r_i + ONE_C;
    assign j_nxt       = r_j + ONE_C;
    assign k_nxt       = r_k + ONE_C;

    // run bounds, clipped to the set size
    assign cnt_ext = SW'(r_count);
    assign mid_sum = SW'(r_lo) + SW'(r_width);
    assign hi_sum  = SW'(r_lo) + {r_width, 1'b0};
    assign mid_c   = (mid_sum > cnt_ext) ? r_count : mid_sum[CW-1:0];
    assign hi_c    = (hi_sum > cnt_ext) ? r_count : hi_sum[CW-1:0];
    assign width2  = {r_width[WW-2:0], 1'b0};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_lo         = r_lo;
        n_mid        = r_mid;
        n_hi         = r_hi;
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;
        n_width      = r_width;
        n_src        = r_src;
        n_ovf        = r_ovf;
        n_set_drop   = r_set_drop;
        n_fresh_a    = 1'b0;
        n_fresh_b    = 1'b0;
        n_rd_pending = 1'b0;
        n_rd_last    = r_rd_last;
        n_out_valid  = r_out_valid;
        we_a         = 1'b0;
        we_b         = 1'b0;
        waddr        = r_count[AW-1:0];
        wr_data      = in_value;
        raddr        = r_k[AW-1:0];

        // output register: the pending read lands here; it is only issued when free
        if (r_rd_pending) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_LOAD: begin
                if (in_accept) begin
                    we_a    = stored;
                    n_count = count_after;
                    if (!stored) begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_final_item) begin
                        n_set_drop = r_ovf || !stored;
                        n_ovf      = 1'b0;
                        n_src      = 1'b0;
                        n_width    = WW'(1);
                        n_lo       = '0;
                        n_k        = '0;
                        n_state    = (count_after < CW'(2)) ? S_EMIT : S_PRIME_A;
                    end
                end
            end

            S_PRIME_A: begin
                raddr     = r_lo[AW-1:0];
                n_fresh_a = 1'b1;
                n_mid     = mid_c;
                n_hi      = hi_c;
                n_i       = r_lo;
                n_j       = mid_c;
                n_k       = r_lo;
                n_state   = (mid_c < hi_c) ? S_PRIME_B : S_MERGE;
            end

            S_PRIME_B: begin
                raddr     = r_mid[AW-1:0];
                n_fresh_b = 1'b1;
                n_state   = S_MERGE;
            end

            S_MERGE: begin
                waddr   = r_k[AW-1:0];
                wr_data = take_a ? head_a : head_b;
                we_a    = r_src;
                we_b    = !r_src;
                n_k     = k_nxt;
                if (take_a) begin
                    n_i       = i_nxt;
                    raddr     = i_nxt[AW-1:0];
                    n_fresh_a = (i_nxt < r_mid);
                end else begin
                    n_j       = j_nxt;
                    raddr     = j_nxt[AW-1:0];
                    n_fresh_b = (j_nxt < r_hi);
                end
                if (k_nxt == r_hi) begin
                    if (r_hi == r_count) begin
                        // pass complete: swap roles, double the run width
                        n_src   = !r_src;
                        n_width = width2;
                        n_lo    = '0;
                        if (width2 >= WW'(r_count)) begin
                            n_k     = '0;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_PRIME_A;
                        end
                    end else begin
                        n_lo    = r_hi;
                        n_state = S_PRIME_A;
                    end
                end
            end

            S_EMIT: begin
                if (!r_rd_pending && (!r_out_valid || !i_out_stall)) begin
                    n_rd_pending = 1'b1;
                    n_rd_last    = (k_nxt == r_count);
                    n_k          = k_nxt;
                    if (k_nxt == r_count) begin
                        n_count = '0;
                        n_state = S_LOAD;
                    end
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_count      <= '0;
            r_lo         <= '0;
            r_mid        <= '0;
            r_hi         <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
            r_width      <= '0;
            r_src        <= 1'b0;
            r_ovf        <= 1'b0;
            r_set_drop   <= 1'b0;
            r_fresh_a    <= 1'b0;
            r_fresh_b    <= 1'b0;
            r_rd_pending <= 1'b0;
            r_rd_last    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_lo         <= n_lo;
            r_mid        <= n_mid;
            r_hi         <= n_hi;
            r_i          <= n_i;
            r_j          <= n_j;
            r_k          <= n_k;
            r_width      <= n_width;
            r_src        <= n_src;
            r_ovf        <= n_ovf;
            r_set_drop   <= n_set_drop;
            r_fresh_a    <= n_fresh_a;
            r_fresh_b    <= n_fresh_b;
            r_rd_pending <= n_rd_pending;
            r_rd_last    <= n_rd_last;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_a <= head_a;
        r_head_b <= head_b;
        if (r_rd_pending) begin
            r_out_value <= PORT_WIDTH'(rdata);
            r_out_end   <= r_rd_last;
            r_out_drop  <= r_set_drop;
        end
    end

    assign o_in_stall          = (r_state != S_LOAD);
    assign o_out_valid         = r_out_valid;
    assign o_out_sorted_value  = r_out_value;
    assign o_out_end_of_run    = r_out_end;
    assign o_out_dropped_items = r_out_drop;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_C)
        else $error("fill count above capacity");

    a_merge_cursors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (SW'(r_i) + SW'(r_j) == SW'(r_k) + SW'(r_mid)))
        else $error("merge cursors out of step");

    a_merge_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (r_k < r_hi && r_i <= r_mid && r_j <= r_hi))
        else $error("merge cursor past its run");

    a_one_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fresh_a && r_fresh_b))
        else $error("two heads refetched in one cycle");

    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_rd_pending))
        else $error("output valid without a read");

endmodule

// ===== verif/merge_sort_engine_top_test.sv =====
// Testbench for merge_sort_engine_top: random and directed sets, sorted-output scoreboard.
`timescale 1ns / 1ps

module merge_sort_engine_top_test import mse_pkg::*; ();

    localparam int MAX_ITEMS   = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int CYCLE_LIMIT = 400000;   // far above the slowest correct run
    localparam int DRAIN_WAIT  = 40;       // quiet cycles after the last result
    localparam int REPORT_MAX  = 10;

    // One input transfer as queued for the driver.
    typedef struct {
        logic signed [PORT_WIDTH-1:0] value;
        logic                         final_flag;
    } t_sample;

    // One output transfer as the sorter should produce it.
    typedef struct {
        logic signed [PORT_WIDTH-1:0] value;
        logic                         last;
        logic                         dropped;
    } t_sorted;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic signed [PORT_WIDTH-1:0] i_in_sample_value = '0;
    logic                         i_in_final_item = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic signed [PORT_WIDTH-1:0] o_out_sorted_value;
    logic                         o_out_end_of_run;
    logic                         o_out_dropped_items;

    t_sample                      samples_to_send[$];
    t_sample                      next_sample;
    t_sorted                      sorted_expected[$];

    // Predictor state: the set gathered so far and its overflow flag.
    logic signed [PORT_WIDTH-1:0] held_vals[$];
    logic                         held_overflow = 1'b0;

    int items_total    = 0;
    int items_accepted = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    always #6 i_clk = ~i_clk;

    merge_sort_engine_top #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_in_sample_value   (i_in_sample_value),
        .i_in_final_item     (i_in_final_item),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_sorted_value  (o_out_sorted_value),
        .o_out_end_of_run    (o_out_end_of_run),
        .o_out_dropped_items (o_out_dropped_items)
    );

    // Idle profile, by how far the input stream has got:
    //   first third  - sender idles 17%, receiver stalls 72%
    //   second third - swapped
    //   last third   - no idling on either side
    function automatic int sender_idle_pct();
        if (items_accepted < items_total / 3) begin
            return 17;
        end else if (items_accepted < (2 * items_total) / 3) begin
            return 72;
        end
        return 0;
    endfunction

    function automatic int receiver_stall_pct();
        if (items_accepted < items_total / 3) begin
            return 72;
        end else if (items_accepted < (2 * items_total) / 3) begin
            return 17;
        end
        return 0;
    endfunction

    // Predictor. Values past capacity are dropped and flag the whole set. On the
    // final transfer the held set is sorted ascending (signed) and queued as the
    // expected run. Equal values look identical on the port, so the tie order of
    // the hardware merge (right run first) cannot show and is not modeled.
    task automatic gather_sample(input logic signed [PORT_WIDTH-1:0] value,
                                 input logic final_flag);
        logic signed [PORT_WIDTH-1:0] ordered[$];
        int                           pos;
        t_sorted                      res;
        if (held_vals.size() < MAX_ITEMS) begin
            held_vals.push_back(value);
        end else begin
            held_overflow = 1'b1;
        end
        if (final_flag) begin
            foreach (held_vals[i]) begin
                pos = 0;
                while (pos < ordered.size() && ordered[pos] <= held_vals[i]) begin
                    pos++;
                end
                ordered.insert(pos, held_vals[i]);
            end
            foreach (ordered[k]) begin
                res.value   = ordered[k];
                res.last    = (k == ordered.size() - 1);
                res.dropped = held_overflow;
                sorted_expected.push_back(res);
            end
            held_vals.delete();
            held_overflow = 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what);
        if (mismatches < REPORT_MAX) begin
            $display("%0t mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    // Compare one output transfer against the oldest expected result.
    task automatic check_sorted();
        t_sorted exp_res;
        if (sorted_expected.size() == 0) begin
            note_mismatch($sformatf("unexpected result value=%0d last=%0b dropped=%0b",
                                    o_out_sorted_value, o_out_end_of_run,
                                    o_out_dropped_items));
        end else begin
            exp_res = sorted_expected.pop_front();
            if (o_out_sorted_value !== exp_res.value) begin
                note_mismatch($sformatf("sorted_value expected %0d got %0d",
                                        exp_res.value, o_out_sorted_value));
            end
            if (o_out_end_of_run !== exp_res.last) begin
                note_mismatch($sformatf("end_of_run expected %0b got %0b",
                                        exp_res.last, o_out_end_of_run));
            end
            if (o_out_dropped_items !== exp_res.dropped) begin
                note_mismatch($sformatf("dropped_items expected %0b got %0b",
                                        exp_res.dropped, o_out_dropped_items));
            end
        end
    endtask

    task automatic queue_sample(input logic signed [PORT_WIDTH-1:0] value,
                                input logic final_flag);
        t_sample s;
        s.value      = value;
        s.final_flag = final_flag;
        samples_to_send.push_back(s);
    endtask

    // Mostly full-range values; some from a narrow band to force duplicates,
    // some pinned to the signed extremes.
    function automatic logic signed [PORT_WIDTH-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) begin
            return $urandom;
        end else if (roll < 85) begin
            return $signed($urandom_range(8)) - 4;
        end else if (roll < 92) begin
            return 32'sh7fff_ffff;
        end
        return 32'sh8000_0000;
    endfunction

    task automatic queue_random_set(input int count);
        for (int i = 0; i < count; i++) begin
            queue_sample(pick_value(), i == count - 1);
        end
    endtask

    // Driver: a transfer completes on an edge with valid high and stall low; the
    // payload is only replaced once the current one has gone or none is posted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                gather_sample(i_in_sample_value, i_in_final_item);
                items_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (samples_to_send.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct()) begin
                    next_sample        = samples_to_send.pop_front();
                    i_in_valid        <= 1'b1;
                    i_in_sample_value <= next_sample.value;
                    i_in_final_item   <= next_sample.final_flag;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every output transfer and drives random back-pressure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[merge_sort_engine_top] ERROR");
            $finish;
        end else if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_sorted();
            end
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct());
        end
    end

    initial begin
        // Directed: signed extremes, zero and -1 with duplicates, in one set.
        queue_sample(32'sh7fff_ffff, 1'b0);
        queue_sample(32'sh8000_0000, 1'b0);
        queue_sample(32'sh0000_0000, 1'b0);
        queue_sample(-32'sd1, 1'b0);
        queue_sample(32'sh0000_0001, 1'b0);
        queue_sample(-32'sd1, 1'b0);
        queue_sample(32'sh8000_0000, 1'b0);
        queue_sample(32'sh7fff_ffff, 1'b1);
        // Single-value set: one result carrying the end-of-run mark.
        queue_sample(-32'sd5, 1'b1);
        // Already ascending.
        for (int i = 0; i < 4; i++) begin
            queue_sample(32'sd10 * i - 32'sd15, i == 3);
        end
        // Descending with repeats, crossing zero.
        queue_sample(32'sd300, 1'b0);
        queue_sample(32'sd300, 1'b0);
        queue_sample(32'sd2, 1'b0);
        queue_sample(-32'sd2, 1'b0);
        queue_sample(-32'sd300, 1'b0);
        queue_sample(-32'sd300, 1'b1);

        // Random: one set exactly at capacity, one that overflows (the final
        // transfer is itself dropped), then mostly small sets with an
        // occasional large or overflowing one.
        queue_random_set(MAX_ITEMS);
        queue_random_set(MAX_ITEMS + 3);
        while (samples_to_send.size() < 372) begin
            if ($urandom_range(99) < 6) begin
                queue_random_set($urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 4));
            end else begin
                queue_random_set($urandom_range(1, 12));
            end
        end
        items_total = samples_to_send.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Poll on the falling edge, away from the clocked updates.
        while (items_accepted != items_total) @(negedge i_clk);
        while (sorted_expected.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (sorted_expected.size() != 0) begin
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("[merge_sort_engine_top] OK");
        end else begin
            $display("[merge_sort_engine_top] ERROR");
        end
        $finish;
    end

endmodule
